@@ rtl/ala_pkg.sv @@
// shared types and codes for the address lease allocator
// no dependencies
`default_nettype none

package ala_pkg;

    localparam int MAC_W  = 48;
    localparam int ADDR_W = 32;

    localparam logic [1:0] OP_DISCOVER = 2'd0;
    localparam logic [1:0] OP_REQUEST  = 2'd1;
    localparam logic [1:0] OP_RELEASE  = 2'd2;
    localparam logic [1:0] OP_QUERY    = 2'd3;

    localparam logic [1:0] REPLY_NONE  = 2'd0;
    localparam logic [1:0] REPLY_OFFER = 2'd1;
    localparam logic [1:0] REPLY_ACK   = 2'd2;
    localparam logic [1:0] REPLY_NAK   = 2'd3;

    localparam logic [1:0] CFG_POOL_FIRST = 2'd0;
    localparam logic [1:0] CFG_POOL_LAST  = 2'd1;
    localparam logic [1:0] CFG_NET_MASK   = 2'd2;

    typedef struct packed {
        logic [MAC_W-1:0]  mac;
        logic [ADDR_W-1:0] addr;
    } entry_t;

endpackage

`default_nettype wire

@@ rtl/ala_entry_ram.sv @@
// binding table storage: one write port, one registered read port
// depends on ala_pkg for the entry type
`default_nettype none

module ala_entry_ram
    import ala_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int IW    = 6
)
(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [IW-1:0] waddr,
    input  wire entry_t        wdata,
    input  wire logic [IW-1:0] raddr,
    output entry_t             rdata
);

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/address_lease_allocator_unit.sv @@
// each item first sweeps the table for the mac; a discover then sweeps the table again for each
// pool candidate tried, at most min(pool size, TABLE_ENTRIES + 1) candidates, and the result
// then goes to the output register
// one item at a time: an item is taken only in the idle state; the next item is taken while
// the result waits on the output
// reset: table empty, pool registers zero, mask 0xffffff00, no clearing pass
`default_nettype none

module address_lease_allocator_unit
    import ala_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [111:0]  s_tdata,   // client_mac, option_addr, client_addr
    input  wire logic [1:0]    s_tuser,   // op
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [71:0]        m_tdata,   // assigned_addr, bcast_addr, table_full, zeros
    output logic [1:0]         m_tuser,   // reply_kind
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [31:0]   cfg_data
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int TW = $clog2(TABLE_ENTRIES + 2);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FIND = 2'd1;
    localparam logic [1:0] ST_CAND = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [ADDR_W-1:0] pool_first_reg, pool_last_reg, net_mask_reg, next_cand_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;

    logic [1:0]        op_reg;
    logic [MAC_W-1:0]  mac_reg;
    logic [ADDR_W-1:0] opt_reg, cli_reg;

    logic [CW-1:0]     cnt_reg;
    logic              pend_reg;
    logic [IW-1:0]     pend_idx_reg;

    logic              found_reg, free_found_reg, held_reg;
    logic [IW-1:0]     eidx_reg, free_idx_reg, slot_reg;
    logic [ADDR_W-1:0] eaddr_reg, cand_reg;
    logic [TW-1:0]     tries_reg;

    logic [1:0]        res_kind_reg;
    logic [ADDR_W-1:0] res_addr_reg;
    logic              res_full_reg;

    logic              out_valid_reg;
    logic [1:0]        out_kind_reg;
    logic [ADDR_W-1:0] out_addr_reg, out_bcast_reg;
    logic              out_full_reg;

    entry_t            rdata;
    entry_t            wdata;
    logic              we;
    logic              sweep_done;
    logic [ADDR_W:0]   pool_size;
    logic [ADDR_W-1:0] cand_step, want, start_cand;

    assign sweep_done = (cnt_reg == CW'(TABLE_ENTRIES)) && !pend_reg;
    assign pool_size  = {1'b0, pool_last_reg} - {1'b0, pool_first_reg} + (ADDR_W+1)'(1);
    assign cand_step  = (cand_reg == pool_last_reg) ? pool_first_reg : cand_reg + ADDR_W'(1);
    assign start_cand = (next_cand_reg < pool_first_reg || next_cand_reg > pool_last_reg)
                        ? pool_first_reg : next_cand_reg;
    assign want = (opt_reg != '0) ? opt_reg :
                  (cli_reg != '0) ? cli_reg :
                  (found_reg ? eaddr_reg : '0);

    assign wdata.mac  = mac_reg;
    assign wdata.addr = cand_reg;
    assign we = (state_reg == ST_CAND) && sweep_done && !held_reg;

    ala_entry_ram #(
        .DEPTH (TABLE_ENTRIES),
        .IW    (IW)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (slot_reg),
        .wdata (wdata),
        .raddr (cnt_reg[IW-1:0]),
        .rdata (rdata)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_kind_reg;
    assign m_tdata   = {7'd0, out_full_reg, out_bcast_reg, out_addr_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_FIND;
                end
            end
            ST_FIND:
            begin
                if (sweep_done && op_reg == OP_DISCOVER && (found_reg || free_found_reg)
                    && !(pool_last_reg < pool_first_reg))
                begin
                    state_next = ST_CAND;
                end
                else if (sweep_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_CAND:
            begin
                if (sweep_done && (!held_reg || tries_reg == TW'(1)))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pool_first_reg <= '0;
            pool_last_reg  <= '0;
            net_mask_reg   <= 32'hffffff00;
            next_cand_reg  <= '0;
            valid_reg      <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_POOL_FIRST:
                    begin
                        pool_first_reg <= cfg_data;
                        next_cand_reg  <= cfg_data;
                    end
                    CFG_POOL_LAST:
                    begin
                        pool_last_reg <= cfg_data;
                    end
                    CFG_NET_MASK:
                    begin
                        net_mask_reg <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end

            // sweep read pipeline
            if ((state_reg == ST_FIND || state_reg == ST_CAND)
                && cnt_reg != CW'(TABLE_ENTRIES))
            begin
                pend_reg <= 1'b1;
            end
            else
            begin
                pend_reg <= 1'b0;
            end

            if (we)
            begin
                valid_reg[slot_reg] <= 1'b1;
                next_cand_reg       <= cand_step;
            end

            if (state_reg == ST_FIND && sweep_done && op_reg == OP_RELEASE && found_reg)
            begin
                valid_reg[eidx_reg] <= 1'b0;
            end

            if (state_reg == ST_OUT && (!out_valid_reg || m_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= cnt_reg[IW-1:0];
        if ((state_reg == ST_FIND || state_reg == ST_CAND)
            && cnt_reg != CW'(TABLE_ENTRIES))
        begin
            cnt_reg <= cnt_reg + CW'(1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                op_reg         <= s_tuser;
                mac_reg        <= s_tdata[47:0];
                opt_reg        <= s_tdata[79:48];
                cli_reg        <= s_tdata[111:80];
                cnt_reg        <= '0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end
            ST_FIND:
            begin
                if (pend_reg && valid_reg[pend_idx_reg] && rdata.mac == mac_reg && !found_reg)
                begin
                    found_reg <= 1'b1;
                    eidx_reg  <= pend_idx_reg;
                    eaddr_reg <= rdata.addr;
                end
                if (pend_reg && !valid_reg[pend_idx_reg] && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= pend_idx_reg;
                end
                if (sweep_done)
                begin
                    res_full_reg <= 1'b0;
                    res_kind_reg <= REPLY_NONE;
                    res_addr_reg <= '0;
                    case (op_reg)
                        OP_DISCOVER:
                        begin
                            res_full_reg <= !found_reg && !free_found_reg;
                            slot_reg     <= found_reg ? eidx_reg : free_idx_reg;
                            cand_reg     <= start_cand;
                            held_reg     <= (start_cand == '0);
                            cnt_reg      <= '0;
                            tries_reg    <= (pool_size > (ADDR_W+1)'(TABLE_ENTRIES + 1))
                                            ? TW'(TABLE_ENTRIES + 1) : pool_size[TW-1:0];
                        end
                        OP_REQUEST:
                        begin
                            if (found_reg && eaddr_reg == want)
                            begin
                                res_kind_reg <= REPLY_ACK;
                                res_addr_reg <= eaddr_reg;
                            end
                            else
                            begin
                                res_kind_reg <= REPLY_NAK;
                            end
                        end
                        OP_QUERY:
                        begin
                            res_addr_reg <= found_reg ? eaddr_reg : '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CAND:
            begin
                if (pend_reg && valid_reg[pend_idx_reg] && rdata.addr == cand_reg)
                begin
                    held_reg <= 1'b1;
                end
                if (sweep_done)
                begin
                    if (!held_reg)
                    begin
                        res_kind_reg <= REPLY_OFFER;
                        res_addr_reg <= cand_reg;
                    end
                    else
                    begin
                        cand_reg  <= cand_step;
                        held_reg  <= (cand_step == '0);
                        tries_reg <= tries_reg - TW'(1);
                        cnt_reg   <= '0;
                    end
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_kind_reg  <= res_kind_reg;
                    out_addr_reg  <= res_addr_reg;
                    out_bcast_reg <= (res_addr_reg != '0) ? (res_addr_reg | ~net_mask_reg) : '0;
                    out_full_reg  <= res_full_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/ala_checker.sv @@
// port-level checks for address_lease_allocator_unit, attached by bind
// depends on ala_pkg for reply codes
`default_nettype none

module ala_checker
    import ala_pkg::*;
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [71:0]  m_tdata,
    input wire logic [1:0]   m_tuser
);

    // one item in flight: busy right after an input transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[64] |-> m_tuser == REPLY_NONE && m_tdata[63:0] == '0)
        else $error("table full with a reply");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == REPLY_NAK |-> m_tdata[63:0] == '0)
        else $error("nak carries an address");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == REPLY_OFFER |-> m_tdata[31:0] != '0)
        else $error("offer of address zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output changed");

endmodule

bind address_lease_allocator_unit ala_checker u_ala_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
